@@ design/hdw_pkg.sv @@
package hdw_pkg;

   localparam int GRID_SIZE_DEF = 512;
   localparam int MAX_STEPS_DEF = 100;

   localparam int COORD_W  = 17;
   localparam int HEIGHT_W = 16;
   localparam int CELL_W   = 9;
   localparam int STEPS_W  = 7;
   localparam int CSR_W    = 17;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_X    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_Y    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_RADIUS = 2'd2;

   localparam logic [CSR_W-1:0] TARGET_X_RST    = 17'd11520;
   localparam logic [CSR_W-1:0] TARGET_Y_RST    = 17'd25600;
   localparam logic [CSR_W-1:0] STOP_RADIUS_RST = 17'd2560;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_WALK  = 1'b1;

   typedef struct packed {
      logic                operation;
      logic [CELL_W-1:0]   cell_x;
      logic [CELL_W-1:0]   cell_y;
      logic [HEIGHT_W-1:0] cell_height;
      logic [COORD_W-1:0]  start_x;
      logic [COORD_W-1:0]  start_y;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] final_x;
      logic [COORD_W-1:0] final_y;
      logic [STEPS_W-1:0] steps_taken;
      logic               reached;
   } rsp_type;

   typedef enum logic [1:0] {
      RD_CENTER = 2'd0,
      RD_RIGHT  = 2'd1,
      RD_DOWN   = 2'd2
   } rd_sel_type;

   typedef struct packed {
      logic       load_walk;
      logic       write_cell;
      logic       mul_dist;
      logic       latch_far;
      rd_sel_type rd_sel;
      logic       lat_h0;
      logic       lat_h1;
      logic       lat_h2;
      logic       grad;
      logic       mul_grad;
      logic       norm;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       div_init;
      logic       div_sel_y;
      logic       div_step;
      logic       div_store;
      logic       move;
      logic       step_only;
   } cmd_type;

   typedef struct packed {
      logic far;
      logic limit;
      logic n2_zero;
      logic cnt_zero;
   } status_type;

endpackage

@@ design/hdw_ram.sv @@
module hdw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/hdw_dp.sv @@
module hdw_dp #(
   parameter int GRID_SIZE = hdw_pkg::GRID_SIZE_DEF,
   parameter int MAX_STEPS = hdw_pkg::MAX_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [hdw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hdw_pkg::CSR_W-1:0]     csr_wdata,
   input  hdw_pkg::req_type              req_data,
   input  hdw_pkg::cmd_type              cmd,
   output hdw_pkg::status_type           status,
   output hdw_pkg::rsp_type              rsp_data
);

   localparam int GW  = $clog2(GRID_SIZE);
   localparam int UW  = (GW + 8 > 17) ? GW + 8 : 17;
   localparam int SW  = UW + 2;
   localparam int CIW = UW - 8;
   localparam int AW  = $clog2(GRID_SIZE * GRID_SIZE);
   localparam int STW = $clog2(MAX_STEPS + 1);
   localparam int PW  = 2 * SW;
   localparam logic signed [SW-1:0] X_LIM = SW'(GRID_SIZE * 256);
   localparam logic signed [SW-1:0] X_TOP = SW'((GRID_SIZE - 1) * 256);

   logic [16:0] tx_ff, ty_ff, rad_ff;
   logic [33:0] r2_ff;
   logic [UW-1:0] x_ff, y_ff, x_in, y_in;
   logic [STW-1:0] steps_ff;
   logic far_ff;
   logic [15:0] h0_ff, h1_ff, h2_ff;
   logic signed [16:0] gx_ff, gy_ff;
   logic [PW-1:0] sqa_ff, sqb_ff;
   logic [32:0] n2_ff;
   logic [49:0] src_ff;
   logic [26:0] rem_ff;
   logic [24:0] root_ff;
   logic [4:0] cnt_ff;
   logic [32:0] drem_ff, dd_ff;
   logic [8:0] q_ff;
   logic signed [9:0] ux_ff, uy_ff;

   logic [CIW-1:0] cx, cy;
   logic [GW-1:0] cx_sat, cy_sat, cx_nx, cy_nx, rd_ax, rd_ay;
   logic cx_edge, cy_edge;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [15:0] rd_data;
   logic wr_en;
   logic signed [16:0] hdx, hdy;
   logic signed [SW-1:0] ma, mb;
   logic [PW:0] dsum;
   logic [28:0] rem_n, trial;
   logic signed [16:0] gsel, gneg;
   logic [15:0] mag;
   logic [32:0] num;
   logic [8:0] qc;
   logic signed [9:0] uv;
   logic signed [SW-1:0] nx, ny;

   assign cx = x_ff[UW-1:8];
   assign cy = y_ff[UW-1:8];
   assign cx_edge = cx >= CIW'(GRID_SIZE - 1);
   assign cy_edge = cy >= CIW'(GRID_SIZE - 1);
   assign cx_sat = cx_edge ? GW'(GRID_SIZE - 1) : cx[GW-1:0];
   assign cy_sat = cy_edge ? GW'(GRID_SIZE - 1) : cy[GW-1:0];
   assign cx_nx = cx_edge ? cx_sat : cx_sat + 1'b1;
   assign cy_nx = cy_edge ? cy_sat : cy_sat + 1'b1;

   always_comb begin
      case (cmd.rd_sel)
         hdw_pkg::RD_RIGHT: begin
            rd_ax = cx_nx;
            rd_ay = cy_sat;
         end
         hdw_pkg::RD_DOWN: begin
            rd_ax = cx_sat;
            rd_ay = cy_nx;
         end
         default: begin
            rd_ax = cx_sat;
            rd_ay = cy_sat;
         end
      endcase
   end

   assign rd_addr = AW'(rd_ax) * AW'(GRID_SIZE) + AW'(rd_ay);
   assign wr_addr = AW'(32'(req_data.cell_x) * GRID_SIZE + 32'(req_data.cell_y));
   assign wr_en = cmd.write_cell && (32'(req_data.cell_x) < GRID_SIZE)
      && (32'(req_data.cell_y) < GRID_SIZE);

   hdw_ram #(
      .WIDTH(hdw_pkg::HEIGHT_W),
      .DEPTH(GRID_SIZE * GRID_SIZE)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_data.cell_height),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_ff  <= hdw_pkg::TARGET_X_RST;
         ty_ff  <= hdw_pkg::TARGET_Y_RST;
         rad_ff <= hdw_pkg::STOP_RADIUS_RST;
      end else if (csr_we) begin
         case (csr_index)
            hdw_pkg::CSR_TARGET_X:    tx_ff  <= csr_wdata;
            hdw_pkg::CSR_TARGET_Y:    ty_ff  <= csr_wdata;
            hdw_pkg::CSR_STOP_RADIUS: rad_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign hdx = $signed({1'b0, h1_ff}) - $signed({1'b0, h0_ff});
   assign hdy = $signed({1'b0, h2_ff}) - $signed({1'b0, h0_ff});

   always_comb begin
      if (cmd.mul_grad) begin
         ma = SW'(gx_ff);
         mb = SW'(gy_ff);
      end else begin
         ma = $signed(SW'(x_ff)) - $signed(SW'(tx_ff));
         mb = $signed(SW'(y_ff)) - $signed(SW'(ty_ff));
      end
   end

   assign dsum = (PW+1)'(sqa_ff) + (PW+1)'(sqb_ff);

   assign rem_n = {2'b00, rem_ff} << 2 | 29'(src_ff[49:48]);
   assign trial = {2'b00, root_ff, 2'b01};

   assign gsel = cmd.div_sel_y ? gy_ff : gx_ff;
   assign gneg = -gsel;
   assign mag  = gsel[16] ? gneg[15:0] : gsel[15:0];
   assign num  = {1'b0, mag, 16'b0} + 33'(root_ff >> 1);
   assign qc   = (q_ff > 9'd256) ? 9'd256 : q_ff;
   assign uv   = gsel[16] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});

   assign nx = $signed(SW'(x_ff)) - SW'(ux_ff);
   assign ny = $signed(SW'(y_ff)) - SW'(uy_ff);

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (nx >= X_LIM) begin
         x_in = UW'(X_TOP);
      end else if (nx < 0) begin
         x_in = '0;
      end else begin
         x_in = UW'(nx);
      end
      if (ny >= X_LIM) begin
         y_in = UW'(X_TOP);
      end else if (ny < 0) begin
         y_in = '0;
      end else begin
         y_in = UW'(ny);
      end
   end

   always_ff @(posedge clock) begin
      r2_ff <= 34'(rad_ff) * 34'(rad_ff);
      if (cmd.load_walk) begin
         x_ff     <= UW'(req_data.start_x);
         y_ff     <= UW'(req_data.start_y);
         steps_ff <= '0;
      end
      if (cmd.move) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
      end
      if (cmd.move || cmd.step_only) begin
         steps_ff <= steps_ff + 1'b1;
      end
      if (cmd.mul_dist || cmd.mul_grad) begin
         sqa_ff <= $unsigned(PW'(ma) * PW'(ma));
         sqb_ff <= $unsigned(PW'(mb) * PW'(mb));
      end
      if (cmd.latch_far) begin
         far_ff <= dsum > (PW+1)'(r2_ff);
      end
      if (cmd.lat_h0) begin
         h0_ff <= rd_data;
      end
      if (cmd.lat_h1) begin
         h1_ff <= rd_data;
      end
      if (cmd.lat_h2) begin
         h2_ff <= rd_data;
      end
      if (cmd.grad) begin
         gx_ff <= cx_edge ? '0 : hdx;
         gy_ff <= cy_edge ? '0 : hdy;
      end
      if (cmd.norm) begin
         n2_ff <= 33'(dsum);
      end
      if (cmd.sqrt_init) begin
         src_ff  <= {1'b0, n2_ff, 16'b0};
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= 5'd24;
      end
      if (cmd.sqrt_step) begin
         src_ff <= src_ff << 2;
         cnt_ff <= cnt_ff - 1'b1;
         if (rem_n >= trial) begin
            rem_ff  <= 27'(rem_n - trial);
            root_ff <= {root_ff[23:0], 1'b1};
         end else begin
            rem_ff  <= rem_n[26:0];
            root_ff <= {root_ff[23:0], 1'b0};
         end
      end
      if (cmd.div_init) begin
         drem_ff <= num;
         dd_ff   <= 33'(root_ff) << 8;
         q_ff    <= '0;
         cnt_ff  <= 5'd8;
      end
      if (cmd.div_step) begin
         dd_ff  <= dd_ff >> 1;
         cnt_ff <= cnt_ff - 1'b1;
         if (drem_ff >= dd_ff) begin
            drem_ff <= drem_ff - dd_ff;
            q_ff    <= {q_ff[7:0], 1'b1};
         end else begin
            q_ff    <= {q_ff[7:0], 1'b0};
         end
      end
      if (cmd.div_store) begin
         if (cmd.div_sel_y) begin
            uy_ff <= uv;
         end else begin
            ux_ff <= uv;
         end
      end
   end

   assign status.far      = dsum > (PW+1)'(r2_ff);
   assign status.limit    = steps_ff == STW'(MAX_STEPS);
   assign status.n2_zero  = n2_ff == '0;
   assign status.cnt_zero = cnt_ff == '0;

   assign rsp_data.final_x     = x_ff[16:0];
   assign rsp_data.final_y     = y_ff[16:0];
   assign rsp_data.steps_taken = 7'(steps_ff);
   assign rsp_data.reached     = !far_ff && !status.limit;

endmodule

@@ design/hdw_ctrl.sv @@
module hdw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_op,
   input  hdw_pkg::status_type status,
   output hdw_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_valid
);

   typedef enum logic [20:0] {
      ST_IDLE  = 21'd1 << 0,
      ST_DIST  = 21'd1 << 1,
      ST_CMP   = 21'd1 << 2,
      ST_RD0   = 21'd1 << 3,
      ST_RD1   = 21'd1 << 4,
      ST_RD2   = 21'd1 << 5,
      ST_RD3   = 21'd1 << 6,
      ST_GRAD  = 21'd1 << 7,
      ST_SQR   = 21'd1 << 8,
      ST_NORM  = 21'd1 << 9,
      ST_CHK   = 21'd1 << 10,
      ST_SQRT  = 21'd1 << 11,
      ST_DIVXI = 21'd1 << 12,
      ST_DIVX  = 21'd1 << 13,
      ST_DIVXS = 21'd1 << 14,
      ST_DIVYI = 21'd1 << 15,
      ST_DIVY  = 21'd1 << 16,
      ST_DIVYS = 21'd1 << 17,
      ST_MOVE  = 21'd1 << 18,
      ST_STAY  = 21'd1 << 19,
      ST_DONE  = 21'd1 << 20
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.rd_sel = hdw_pkg::RD_CENTER;
      case (state_ff)
         ST_IDLE: begin
            if (start && req_op == hdw_pkg::OP_WALK) begin
               cmd.load_walk = 1'b1;
               state_in = ST_DIST;
            end else if (start) begin
               cmd.write_cell = 1'b1;
            end
         end
         ST_DIST: begin
            cmd.mul_dist = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.latch_far = 1'b1;
            if (!status.far || status.limit) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_RD0;
            end
         end
         ST_RD0: begin
            cmd.rd_sel = hdw_pkg::RD_CENTER;
            state_in = ST_RD1;
         end
         ST_RD1: begin
            cmd.rd_sel = hdw_pkg::RD_RIGHT;
            cmd.lat_h0 = 1'b1;
            state_in = ST_RD2;
         end
         ST_RD2: begin
            cmd.rd_sel = hdw_pkg::RD_DOWN;
            cmd.lat_h1 = 1'b1;
            state_in = ST_RD3;
         end
         ST_RD3: begin
            cmd.lat_h2 = 1'b1;
            state_in = ST_GRAD;
         end
         ST_GRAD: begin
            cmd.grad = 1'b1;
            state_in = ST_SQR;
         end
         ST_SQR: begin
            cmd.mul_grad = 1'b1;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            cmd.norm = 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (status.n2_zero) begin
               state_in = ST_STAY;
            end else begin
               cmd.sqrt_init = 1'b1;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (status.cnt_zero) begin
               state_in = ST_DIVXI;
            end
         end
         ST_DIVXI: begin
            cmd.div_init = 1'b1;
            state_in = ST_DIVX;
         end
         ST_DIVX: begin
            cmd.div_step = 1'b1;
            if (status.cnt_zero) begin
               state_in = ST_DIVXS;
            end
         end
         ST_DIVXS: begin
            cmd.div_store = 1'b1;
            state_in = ST_DIVYI;
         end
         ST_DIVYI: begin
            cmd.div_init = 1'b1;
            cmd.div_sel_y = 1'b1;
            state_in = ST_DIVY;
         end
         ST_DIVY: begin
            cmd.div_step = 1'b1;
            cmd.div_sel_y = 1'b1;
            if (status.cnt_zero) begin
               state_in = ST_DIVYS;
            end
         end
         ST_DIVYS: begin
            cmd.div_store = 1'b1;
            cmd.div_sel_y = 1'b1;
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            cmd.move = 1'b1;
            state_in = ST_DIST;
         end
         ST_STAY: begin
            cmd.step_only = 1'b1;
            state_in = ST_DIST;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = state_ff == ST_DONE;

`ifndef SYNTHESIS
   a_done_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> state_ff == ST_IDLE)
      else $error("result strobe longer than one cycle");

   a_busy_from_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && req_op == hdw_pkg::OP_WALK))
      else $error("busy without an accepted walk");

   a_limit_stops: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CMP && status.limit |=> state_ff == ST_DONE)
      else $error("walk ran past the step limit");

   a_move_nonflat: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MOVE |-> !status.n2_zero)
      else $error("move on a flat gradient");
`endif

endmodule

@@ design/heightfield_descent_walk.sv @@
// Steepest descent walk over a height table. A write word (operation 0) stores one
// height cell in the accepting cycle and leaves busy low. A walk word (operation 1)
// raises busy and yields exactly one result, shown for one cycle on rsp_valid; the
// receiver cannot stall it. A descent step on a sloped cell runs a distance check,
// table reads, gradient and norm, the bit-pair square root, the shared restoring
// divider for x and then for y, and a move; a step on a flat cell skips the square
// root, the divider and the move and only counts the step. The table needs no clearing
// after reset; cells must be written before a walk reads them.
module heightfield_descent_walk #(
   parameter int GRID_SIZE = hdw_pkg::GRID_SIZE_DEF,
   parameter int MAX_STEPS = hdw_pkg::MAX_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  hdw_pkg::req_type              req_data,
   output logic                          rsp_valid,
   output hdw_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [hdw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hdw_pkg::CSR_W-1:0]     csr_wdata
);

   hdw_pkg::cmd_type    cmd;
   hdw_pkg::status_type status;

   hdw_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_op   (req_data.operation),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy),
      .rsp_valid(rsp_valid)
   );

   hdw_dp #(
      .GRID_SIZE(GRID_SIZE),
      .MAX_STEPS(MAX_STEPS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

@@ sim/tb_heightfield_descent_walk.sv @@
module tb_heightfield_descent_walk;
   timeunit 1ns;
   timeprecision 1ps;
   import hdw_pkg::*;

   localparam int GRID = GRID_SIZE_DEF;
   localparam int STEP_LIMIT = MAX_STEPS_DEF;
   localparam longint COORD_MAX = 131071;
   localparam longint CYCLE_LIMIT = 20000000;

   localparam int HF_BOWL = 0;
   localparam int HF_FLAT = 1;
   localparam int HF_RAMP = 2;
   localparam int HF_NOISE = 3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TARGET_X;
   logic [CSR_W-1:0] csr_wdata = '0;

   heightfield_descent_walk u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   logic [15:0] live_height [0:GRID*GRID-1];
   logic [15:0] plan_height [0:GRID*GRID-1];
   bit plan_written [0:GRID*GRID-1];
   longint tgt_x = TARGET_X_RST;
   longint tgt_y = TARGET_Y_RST;
   longint radius = STOP_RADIUS_RST;

   req_type word_q[$];
   rsp_type walk_result_q[$];
   int words_planned = 0;
   int gap_left = 0;
   bit quiet = 0;
   int mismatches = 0;
   longint cycles = 0;

   bit miss_hit;
   longint miss_x, miss_y;

   function automatic longint cell_height(bit plan, longint cx, longint cy);
      int idx;
      if (cx > GRID - 1) cx = GRID - 1;
      if (cy > GRID - 1) cy = GRID - 1;
      if (cx < 0) cx = 0;
      if (cy < 0) cy = 0;
      idx = int'(cx * GRID + cy);
      if (plan) begin
         if (!plan_written[idx] && !miss_hit) begin
            miss_hit = 1;
            miss_x = cx;
            miss_y = cy;
         end
         return plan_written[idx] ? longint'(plan_height[idx]) : 0;
      end
      return longint'(live_height[idx]);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint unit_step(longint g, longint unsigned s);
      longint unsigned mag, q;
      mag = (g < 0) ? -g : g;
      q = (mag * 65536 + s / 2) / s;
      if (q > 256) q = 256;
      return (g < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic bit off_target(longint x, longint y);
      longint dx, dy;
      dx = x - tgt_x;
      dy = y - tgt_y;
      return (dx * dx + dy * dy) > (radius * radius);
   endfunction

   function automatic rsp_type descend(bit plan, longint sx, longint sy);
      longint x, y, cx, cy, h0, gx, gy;
      longint unsigned n2, s;
      int steps;
      bit far;
      rsp_type r;
      x = sx;
      y = sy;
      steps = 0;
      far = off_target(x, y);
      while (far && steps < STEP_LIMIT && !(plan && miss_hit)) begin
         cx = x >>> 8;
         cy = y >>> 8;
         h0 = cell_height(plan, cx, cy);
         gx = (cx > GRID - 2) ? 0 : cell_height(plan, cx + 1, cy) - h0;
         gy = (cy > GRID - 2) ? 0 : cell_height(plan, cx, cy + 1) - h0;
         n2 = gx * gx + gy * gy;
         if (n2 != 0) begin
            s = int_sqrt(n2 << 16);
            x -= unit_step(gx, s);
            y -= unit_step(gy, s);
            if (x >= GRID * 256) x = (GRID - 1) * 256;
            if (y >= GRID * 256) y = (GRID - 1) * 256;
            if (x < 0) x = 0;
            if (y < 0) y = 0;
         end
         steps++;
         far = off_target(x, y);
      end
      r.final_x = x[COORD_W-1:0];
      r.final_y = y[COORD_W-1:0];
      r.steps_taken = steps[STEPS_W-1:0];
      r.reached = (!far && steps < STEP_LIMIT);
      return r;
   endfunction

   function automatic logic [15:0] height_for(int mode, longint cx, longint cy);
      longint dx, dy, h;
      case (mode)
         HF_FLAT: h = 777;
         HF_RAMP: h = cx * 100;
         HF_NOISE: h = $urandom_range(0, 65535);
         default: begin
            dx = cx - (tgt_x >> 8);
            dy = cy - (tgt_y >> 8);
            h = 40 * (dx * dx + dy * dy) + $urandom_range(0, 3);
         end
      endcase
      if (h > 65535) h = 65535;
      return h[15:0];
   endfunction

   task automatic push_cell(longint cx, longint cy, logic [15:0] h);
      req_type w;
      w = '0;
      w.operation = OP_WRITE;
      w.cell_x = cx[CELL_W-1:0];
      w.cell_y = cy[CELL_W-1:0];
      w.cell_height = h;
      w.start_x = COORD_W'($urandom_range(0, COORD_MAX));
      w.start_y = COORD_W'($urandom_range(0, COORD_MAX));
      plan_height[cx * GRID + cy] = h;
      plan_written[cx * GRID + cy] = 1;
      word_q = {word_q, w};
      words_planned++;
   endtask

   task automatic plan_walk(int mode, longint sx, longint sy, int cap);
      req_type w;
      rsp_type r;
      int added;
      added = 0;
      forever begin
         miss_hit = 0;
         r = descend(1, sx, sy);
         if (!miss_hit) begin
            w.operation = OP_WALK;
            w.cell_x = CELL_W'($urandom_range(0, GRID - 1));
            w.cell_y = CELL_W'($urandom_range(0, GRID - 1));
            w.cell_height = HEIGHT_W'($urandom_range(0, 65535));
            w.start_x = sx[COORD_W-1:0];
            w.start_y = sy[COORD_W-1:0];
            word_q = {word_q, w};
            words_planned++;
            return;
         end
         if (added == cap) return;
         push_cell(miss_x, miss_y, height_for(mode, miss_x, miss_y));
         added++;
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (word_q.size() != 0 || start || busy || walk_result_q.size() != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, longint v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v[CSR_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_TARGET_X: tgt_x = v;
         CSR_TARGET_Y: tgt_y = v;
         CSR_STOP_RADIUS: radius = v;
         default: ;
      endcase
   endtask

   task automatic set_target(longint tx, longint ty, longint r);
      write_csr(CSR_TARGET_X, tx);
      write_csr(CSR_TARGET_Y, ty);
      write_csr(CSR_STOP_RADIUS, r);
      @(posedge clock);
   endtask

   function automatic longint near(longint c);
      longint v;
      v = c + longint'($urandom_range(0, 4096)) - 2048;
      if (v < 0) v = 0;
      if (v > COORD_MAX) v = COORD_MAX;
      return v;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else begin
         if (start && !busy) begin
            if (req_data.operation == OP_WALK)
               walk_result_q = {walk_result_q,
                                descend(0, req_data.start_x, req_data.start_y)};
            else
               live_height[req_data.cell_x * GRID + req_data.cell_y] <= req_data.cell_height;
         end
         if (start && busy) begin
         end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (word_q.size() != 0 && !quiet && $urandom_range(0, 7) == 0) begin
            start <= 1'b0;
            gap_left <= $urandom_range(1, 18) - 1;
         end else if (word_q.size() != 0) begin
            req_data <= word_q.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (walk_result_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected walk result %p", rsp_data);
         end else begin
            rsp_type want;
            want = walk_result_q.pop_front();
            if (rsp_data.final_x !== want.final_x || rsp_data.final_y !== want.final_y ||
                rsp_data.steps_taken !== want.steps_taken ||
                rsp_data.reached !== want.reached) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("walk mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int roll, phase_end;
      longint pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      plan_walk(HF_BOWL, 50 * 256 + 17, 108 * 256 + 200, 200);
      plan_walk(HF_BOWL, TARGET_X_RST, TARGET_Y_RST, 10);
      plan_walk(HF_FLAT, 300 * 256 + 5, 300 * 256 + 9, 10);
      plan_walk(HF_FLAT, COORD_MAX, COORD_MAX, 10);
      push_cell(0, 0, 16'h0000);
      push_cell(0, GRID - 1, 16'hffff);
      push_cell(GRID - 1, 0, 16'h0000);
      plan_walk(HF_BOWL, 40 * 256, 95 * 256, 200);
      wait_idle();

      set_target(10 * 256, 20 * 256 + 128, 0);
      plan_walk(HF_RAMP, 110 * 256, 20 * 256 + 128, 400);
      plan_walk(HF_RAMP, 109 * 256, 20 * 256 + 128, 400);
      wait_idle();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_target(0, 0, 0);
            1: set_target(COORD_MAX, COORD_MAX, COORD_MAX);
            2: set_target($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), 256);
            3: set_target($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                          $urandom_range(0, 1024));
            default: begin
               quiet = 1;
               set_target($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                          $urandom_range(0, 4096));
            end
         endcase
         phase_end = words_planned + 20;
         while (words_planned < phase_end) begin
            roll = $urandom_range(0, 99);
            if (roll < 65)
               plan_walk(HF_BOWL, near(tgt_x), near(tgt_y), 120);
            else if (roll < 75)
               plan_walk(HF_NOISE, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), 30);
            else if (roll < 85) begin
               pick = $urandom_range(0, GRID - 1);
               push_cell(pick, $urandom_range(0, GRID - 1), 16'($urandom_range(0, 65535)));
            end else if (roll < 92)
               plan_walk(HF_FLAT, near(tgt_x), near(tgt_y), 10);
            else
               plan_walk(HF_NOISE, near(tgt_x), near(tgt_y), 30);
         end
         wait_idle();
      end

      if (mismatches == 0 && walk_result_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

@@ files.f @@
design/hdw_pkg.sv
design/hdw_ram.sv
design/hdw_dp.sv
design/hdw_ctrl.sv
design/heightfield_descent_walk.sv
sim/tb_heightfield_descent_walk.sv
